### rtl/core/mf3_pkg.sv
// Shared widths, register indexes and types of the 3x3 median filter.
package mf3_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int ADDR_W       = $clog2(MAX_WIDTH);
	localparam int HEIGHT_LIMIT = 4096;
	localparam int PIX_W        = 8;
	localparam int COL_W        = 11;
	localparam int ROW_W        = 13;
	localparam int CFG_W        = 13;
	localparam int CFG_IDX_W    = 1;
	localparam int TAPS         = 9;
	localparam int RANK_W       = 4;
	localparam int MED_RANK     = 4;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [COL_W-1:0] WIDTH_RESET  = 11'd256;
	localparam logic [ROW_W-1:0] HEIGHT_RESET = 13'd256;

	typedef logic [TAPS-1:0][PIX_W-1:0] win_t;
	typedef logic [2*PIX_W-1:0]         line_pair_t;

	// Position info of the result that an item produces
	typedef struct packed {
		logic has_res;
		logic last;
		logic pad_top;
		logic pad_bot;
		logic pad_left;
		logic pad_right;
	} pos_t;

endpackage

### rtl/core/mf3_if.sv
// Stream interfaces for pixel items and median results.
interface mf3_pix_if;
	import mf3_pkg::*;
	logic             valid;
	logic             ready;
	logic             opcode;
	logic [PIX_W-1:0] pixel_in;
	modport source (output valid, output opcode, output pixel_in, input ready);
	modport sink (input valid, input opcode, input pixel_in, output ready);
endinterface

interface mf3_res_if;
	import mf3_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] median_out;
	logic             frame_last;
	modport source (output valid, output median_out, output frame_last, input ready);
	modport sink (input valid, input median_out, input frame_last, output ready);
endinterface

### rtl/core/mf3_line_store.sv
// Two-row line store: one memory holding {row above-above, row above} per column.
module mf3_line_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  logic [mf3_pkg::ADDR_W-1:0]  waddr,
	input  mf3_pkg::line_pair_t         wdata,
	input  logic                        re,
	input  logic [mf3_pkg::ADDR_W-1:0]  raddr,
	output mf3_pkg::line_pair_t         rdata
);
	import mf3_pkg::*;

	line_pair_t mem [MAX_WIDTH];
	line_pair_t rd_q;
	line_pair_t byp_data_q;
	logic       byp_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re) begin
			rd_q       <= mem[raddr];
			byp_data_q <= wdata;
		end
	end

	// Same-column write in the read cycle (one-pixel rows): take the new data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (re) begin
			byp_q <= we && (waddr == raddr);
		end
	end

	assign rdata = byp_q ? byp_data_q : rd_q;

endmodule

### rtl/core/mf3_ctrl.sv
// Frame registers, column/row counters and edge padding decisions.
module mf3_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mf3_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          accept,
	input  logic                          opcode,
	input  logic [mf3_pkg::PIX_W-1:0]     pixel_in,
	output logic [mf3_pkg::ADDR_W-1:0]    addr,
	output logic [mf3_pkg::PIX_W-1:0]     pix,
	output mf3_pkg::pos_t                 pos
);
	import mf3_pkg::*;

	logic [COL_W-1:0] width_q;
	logic [ROW_W-1:0] height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [COL_W-1:0] w_eff;
	logic [ROW_W-1:0] h_eff;
	logic [COL_W-1:0] xc;
	logic [COL_W-1:0] x_next;
	logic [ROW_W:0]   row_ext;
	logic [ROW_W:0]   h_ext;
	logic             x_nz;

	always_comb begin
		w_eff = width_q;
		if (width_q == '0)
			w_eff = COL_W'(1);
		else if (width_q > COL_W'(MAX_WIDTH))
			w_eff = COL_W'(MAX_WIDTH);
		h_eff = height_q;
		if (height_q == '0)
			h_eff = ROW_W'(1);
		else if (height_q > ROW_W'(HEIGHT_LIMIT))
			h_eff = ROW_W'(HEIGHT_LIMIT);
	end

	assign xc      = (col_q >= w_eff) ? '0 : col_q;
	assign x_nz    = (xc != '0);
	assign row_ext = (ROW_W+1)'(row_q);
	assign h_ext   = (ROW_W+1)'(h_eff);
	assign x_next  = xc + COL_W'(1);
	assign addr    = xc[ADDR_W-1:0];

	// Rows past the frame and flush beats feed zeros
	assign pix = (opcode || row_q >= h_eff) ? '0 : pixel_in;

	// Result is for the pixel one row and one column back
	always_comb begin
		pos.has_res   = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && x_nz);
		pos.last      = (row_ext == h_ext + (ROW_W+1)'(1)) && !x_nz;
		pos.pad_top   = x_nz ? (row_q == ROW_W'(1)) : (row_q == ROW_W'(2));
		pos.pad_bot   = x_nz ? (row_q >= h_eff) : (row_ext >= h_ext + (ROW_W+1)'(1));
		pos.pad_left  = x_nz ? (xc == COL_W'(1)) : (w_eff == COL_W'(1));
		pos.pad_right = !x_nz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_wdata[COL_W-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg_wdata[ROW_W-1:0];
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (pos.has_res && pos.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (x_next >= w_eff) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= x_next;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && pos.last && !cfg_wr_en |=> col_q == '0 && row_q == '0)
		else $error("counters not cleared after frame end");

endmodule

### rtl/core/mf3_median.sv
// Zero-padded median of nine taps by parallel rank counting.
module mf3_median (
	input  mf3_pkg::win_t              taps,
	input  mf3_pkg::pos_t              pos,
	output logic [mf3_pkg::PIX_W-1:0]  median
);
	import mf3_pkg::*;

	win_t              t;
	logic [RANK_W-1:0] rank [TAPS];

	// Taps are row major: row 0 is two rows up, column 0 is leftmost
	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			if ((k / 3 == 0 && pos.pad_top) || (k / 3 == 2 && pos.pad_bot) ||
			    (k % 3 == 0 && pos.pad_left) || (k % 3 == 2 && pos.pad_right))
				t[k] = '0;
			else
				t[k] = taps[k];
		end
	end

	// Ties break by tap index so that exactly one tap holds the middle rank
	always_comb begin
		for (int i = 0; i < TAPS; i++) begin
			rank[i] = '0;
			for (int j = 0; j < TAPS; j++) begin
				if (j < i)
					rank[i] = rank[i] + RANK_W'(t[j] <= t[i]);
				else if (j > i)
					rank[i] = rank[i] + RANK_W'(t[j] < t[i]);
			end
		end
	end

	always_comb begin
		median = '0;
		for (int i = 0; i < TAPS; i++) begin
			if (rank[i] == RANK_W'(MED_RANK))
				median = t[i];
		end
	end

endmodule

### rtl/core/median_filter_3x3_top.sv
// Streaming 3x3 median filter: input register, line store, window and result register.
// Throughput: one beat per clock while results are taken; a stalled result holds the input.
// A result passes stage one and then the result register after the beat that completes
//   its window, which is one row plus one pixel after the center pixel (w+1 beats).
// Reset: frame width and height go to 256, counters and window clear; line store
//   contents stay undefined and are masked by position, so no clearing pass runs.
module median_filter_3x3_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mf3_pkg::CFG_W-1:0]     cfg_wdata,
	mf3_pix_if.sink                       pixels,
	mf3_res_if.source                     results
);
	import mf3_pkg::*;

	logic              accept;
	logic              advance;
	logic              wr_en;
	logic [ADDR_W-1:0] addr;
	logic [PIX_W-1:0]  pix;
	pos_t              pos;

	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [PIX_W-1:0]  pix_s1;
	pos_t              pos_s1;

	line_pair_t        rd;
	win_t              win_q;
	win_t              taps_raw;
	logic [PIX_W-1:0]  median;

	logic              res_valid_q;
	logic [PIX_W-1:0]  median_q;
	logic              last_q;

	assign advance      = !res_valid_q || results.ready;
	assign pixels.ready = !valid_s1 || advance;
	assign accept       = pixels.valid && pixels.ready;
	assign wr_en        = valid_s1 && advance;

	mf3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.opcode    (pixels.opcode),
		.pixel_in  (pixels.pixel_in),
		.addr      (addr),
		.pix       (pix),
		.pos       (pos)
	);

	// Upper half: two rows up; lower half: one row up
	mf3_line_store u_lines (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (wr_en),
		.waddr  (addr_s1),
		.wdata  ({rd[PIX_W-1:0], pix_s1}),
		.re     (accept),
		.raddr  (addr),
		.rdata  (rd)
	);

	// Shift the window left by one column and bring in the new column
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			taps_raw[r*3]     = win_q[r*3 + 1];
			taps_raw[r*3 + 1] = win_q[r*3 + 2];
		end
		taps_raw[2] = rd[2*PIX_W-1:PIX_W];
		taps_raw[5] = rd[PIX_W-1:0];
		taps_raw[8] = pix_s1;
	end

	mf3_median u_median (
		.taps   (taps_raw),
		.pos    (pos_s1),
		.median (median)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			win_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pixels.ready)
				valid_s1 <= accept;
			if (wr_en)
				win_q <= taps_raw;
			if (advance)
				res_valid_q <= valid_s1 && pos_s1.has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= addr;
			pix_s1  <= pix;
			pos_s1  <= pos;
		end
		if (wr_en && pos_s1.has_res) begin
			median_q <= median;
			last_q   <= pos_s1.last;
		end
	end

	assign results.valid      = res_valid_q;
	assign results.median_out = median_q;
	assign results.frame_last = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		!pixels.ready |-> valid_s1 && res_valid_q && !results.ready)
		else $error("input held off without a stalled result");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1 && pos_s1.has_res))
		else $error("result raised without a producing item");

	assert property (@(posedge clk) disable iff (!arst_n)
		!wr_en |=> $stable(win_q))
		else $error("window moved without a beat leaving stage one");

endmodule
